[rtl/core/ffbl_pkg.sv]
// Shared types, codes and constants for the first-fit bin loader.
// Used by the channel interfaces, the bin cell, and the top level.
`default_nettype none
package ffbl_pkg;

	localparam int DEF_NUM_BINS = 16;
	localparam int DEF_SLOTS    = 32;

	localparam int CMD_W      = 2;
	localparam int ID_W       = 16;
	localparam int SIZE_W     = 16;
	localparam int RD_BIN_W   = 4;
	localparam int RD_SLOT_W  = 5;
	localparam int STATUS_W   = 3;
	localparam int OUT_BIN_W  = 4;
	localparam int OUT_SLOT_W = 5;
	localparam int ROOM_W     = 16;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// widest bin and slot numbers over the supported parameter range
	localparam int BIN_TW  = 6;
	localparam int SLOT_TW = 8;

	localparam logic [CNT_W-1:0]  CNT_RST = 5'd3;
	localparam logic [ROOM_W-1:0] CAP_RST = 16'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_PLACE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED      = 3'd0,
		ST_NO_FIT      = 3'd1,
		ST_CLEARED     = 3'd2,
		ST_READ_OK     = 3'd3,
		ST_READ_UNUSED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_COUNT = 2'd0,
		REG_BIN_CAP   = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]  bin_count;
		logic [ROOM_W-1:0] capacity;
	} ffbl_cfg_t;

	typedef struct packed {
		logic                 vld;
		cmd_t                 cmd;
		logic [SIZE_W-1:0]    size;
		logic [RD_BIN_W-1:0]  rd_bin;
		logic [RD_SLOT_W-1:0] rd_slot;
		logic                 hit;
		logic [BIN_TW-1:0]    bin;
		logic [SLOT_TW-1:0]   slot;
		logic [ROOM_W-1:0]    rem;
	} ffbl_tok_t;

endpackage
`default_nettype wire

[rtl/core/ffbl_if.sv]
// Valid/ready channel interfaces: command request, result response, register write.
// Depends on ffbl_pkg for field widths.
`default_nettype none
interface ffbl_req_if import ffbl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [ID_W-1:0]      item_id;
	logic [SIZE_W-1:0]    item_size;
	logic [RD_BIN_W-1:0]  read_bin;
	logic [RD_SLOT_W-1:0] read_slot;

	modport source (output valid, cmd, item_id, item_size, read_bin, read_slot, input ready);
	modport sink   (input valid, cmd, item_id, item_size, read_bin, read_slot, output ready);
endinterface

interface ffbl_rsp_if import ffbl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [OUT_BIN_W-1:0]  bin_index;
	logic [OUT_SLOT_W-1:0] slot_index;
	logic [ROOM_W-1:0]     remaining;
	logic [ID_W-1:0]       stored_id;

	modport source (output valid, status, bin_index, slot_index, remaining, stored_id,
		input ready);
	modport sink   (input valid, status, bin_index, slot_index, remaining, stored_id,
		output ready);
endinterface

interface ffbl_cfg_if import ffbl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ffbl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffbl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/core/ffbl_cell.sv]
// One bin of the first-fit chain: holds room and fill count, acts on the passing token.
// Depends on ffbl_pkg for the token and register types.
`default_nettype none
module ffbl_cell import ffbl_pkg::*; #(
	parameter int SLOTS_PER_BIN = DEF_SLOTS,
	parameter int IDX = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ffbl_cfg_t regs,
	input  wire ffbl_tok_t prev_tok,
	output ffbl_tok_t      next_tok
);

	localparam int FILL_W = $clog2(SLOTS_PER_BIN + 1);
	localparam int CMP_W  = (FILL_W > RD_SLOT_W) ? FILL_W : RD_SLOT_W;
	localparam int USE_W  = BIN_TW + 1;

	logic [ROOM_W-1:0] room_q;
	logic [FILL_W-1:0] fill_q;
	ffbl_tok_t         tok_q;
	ffbl_tok_t         tok_nxt;
	logic              in_use;
	logic              take;
	logic              rd_hit;
	logic              clr;
	logic [ROOM_W-1:0] room_left;

	assign in_use    = USE_W'(IDX) < USE_W'(regs.bin_count);
	assign room_left = room_q - prev_tok.size;
	assign take = prev_tok.vld && (prev_tok.cmd == CMD_PLACE) && !prev_tok.hit && in_use &&
		(fill_q < FILL_W'(SLOTS_PER_BIN)) && (prev_tok.size <= room_q);
	assign rd_hit = prev_tok.vld && (prev_tok.cmd == CMD_READ) &&
		(BIN_TW'(prev_tok.rd_bin) == BIN_TW'(IDX)) &&
		(CMP_W'(prev_tok.rd_slot) < CMP_W'(fill_q));
	assign clr = prev_tok.vld && (prev_tok.cmd == CMD_CLEAR);

	always_comb begin
		tok_nxt = prev_tok;
		if (take) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.bin  = BIN_TW'(IDX);
			tok_nxt.slot = SLOT_TW'(fill_q);
			tok_nxt.rem  = room_left;
		end
		if (rd_hit) begin
			tok_nxt.hit  = 1'b1;
			tok_nxt.bin  = BIN_TW'(IDX);
			tok_nxt.slot = SLOT_TW'(prev_tok.rd_slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			room_q <= CAP_RST;
			fill_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (clr) begin
				room_q <= regs.capacity;
				fill_q <= '0;
			end else if (take) begin
				room_q <= room_left;
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign next_tok = tok_q;

endmodule
`default_nettype wire

[rtl/core/first_fit_bin_loader.sv]
// First-fit bin loader: a command token walks a chain of NUM_BINS bin cells, one
// cell per cycle; the token leaving the last cell is registered along with its
// slot-memory access, then the result is registered onto the output. The next
// command is taken only after that load, which waits while the output stalls.
// A place takes the lowest enabled bin with enough room and a free slot; a clear
// refills every bin; a read returns the id held in one slot. Commands are taken one
// at a time; a new one is accepted while the previous result waits on the output.
// Register writes are accepted in every cycle and belong between commands.
// Depends on ffbl_pkg, ffbl_if, ffbl_cell and ffbl_ram.
`default_nettype none
module first_fit_bin_loader import ffbl_pkg::*; #(
	parameter int NUM_BINS = DEF_NUM_BINS,
	parameter int SLOTS_PER_BIN = DEF_SLOTS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ffbl_req_if.sink   req,
	ffbl_rsp_if.source rsp,
	ffbl_cfg_if.sink   cfg
);

	localparam int DEPTH  = NUM_BINS * SLOTS_PER_BIN;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_MEM  = 3'b100
	} state_t;

	state_t                state_q;
	ffbl_cfg_t             regs_q;
	logic [ID_W-1:0]       id_q;
	ffbl_tok_t             head;
	ffbl_tok_t             tail;
	ffbl_tok_t             tail_q;
	ffbl_tok_t             tok [NUM_BINS];
	logic [NUM_BINS-1:0]   tok_vld;
	logic                  req_acc;
	logic                  ram_we;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_addr;
	logic [ID_W-1:0]       ram_rdata;
	logic                  load;
	status_t               res_status;
	logic [OUT_BIN_W-1:0]  res_bin;
	logic [OUT_SLOT_W-1:0] res_slot;
	logic [ROOM_W-1:0]     res_rem;
	logic [ID_W-1:0]       res_id;
	logic                  out_vld_q;
	status_t               out_status_q;
	logic [OUT_BIN_W-1:0]  out_bin_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;
	logic [ROOM_W-1:0]     out_rem_q;
	logic [ID_W-1:0]       out_id_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bin_count <= CNT_RST;
			regs_q.capacity  <= CAP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BIN_COUNT: regs_q.bin_count <= cfg.data[CNT_W-1:0];
				REG_BIN_CAP:   regs_q.capacity  <= cfg.data[ROOM_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	always_comb begin
		head         = '0;
		head.vld     = req_acc;
		head.cmd     = cmd_t'(req.cmd);
		head.size    = req.item_size;
		head.rd_bin  = req.read_bin;
		head.rd_slot = req.read_slot;
	end

	for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
		ffbl_tok_t prev;
		if (i == 0) begin : g_head
			assign prev = head;
		end else begin : g_link
			assign prev = tok[i-1];
		end
		ffbl_cell #(
			.SLOTS_PER_BIN(SLOTS_PER_BIN),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.regs(regs_q),
			.prev_tok(prev),
			.next_tok(tok[i])
		);
		assign tok_vld[i] = tok[i].vld;
	end

	assign tail = tok[NUM_BINS-1];

	assign ram_we   = (state_q == S_RUN) && tail.vld && tail.hit && (tail.cmd == CMD_PLACE);
	assign ram_re   = (state_q == S_RUN) && tail.vld && tail.hit && (tail.cmd == CMD_READ);
	assign ram_addr = ADDR_W'(tail.bin) * ADDR_W'(SLOTS_PER_BIN) + ADDR_W'(tail.slot);

	ffbl_ram #(
		.WIDTH(ID_W),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_addr),
		.wdata(id_q),
		.re(ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_status = ST_NO_FIT;
		res_bin    = '0;
		res_slot   = '0;
		res_rem    = '0;
		res_id     = '0;
		case (tail_q.cmd)
			CMD_PLACE: begin
				if (tail_q.hit) begin
					res_status = ST_PLACED;
					res_bin    = tail_q.bin[OUT_BIN_W-1:0];
					res_slot   = tail_q.slot[OUT_SLOT_W-1:0];
					res_rem    = tail_q.rem;
				end
			end
			CMD_CLEAR: res_status = ST_CLEARED;
			CMD_READ: begin
				res_bin  = tail_q.rd_bin;
				res_slot = tail_q.rd_slot;
				if (tail_q.hit) begin
					res_status = ST_READ_OK;
					res_id     = ram_rdata;
				end else begin
					res_status = ST_READ_UNUSED;
				end
			end
			default: ;
		endcase
	end

	assign load = (state_q == S_MEM) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req_acc) state_q <= S_RUN;
				S_RUN:  if (tail.vld) state_q <= S_MEM;
				S_MEM:  if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			id_q <= req.item_id;
		end
		if ((state_q == S_RUN) && tail.vld) begin
			tail_q <= tail;
		end
		if (load) begin
			out_status_q <= res_status;
			out_bin_q    <= res_bin;
			out_slot_q   <= res_slot;
			out_rem_q    <= res_rem;
			out_id_q     <= res_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_status_q;
	assign rsp.bin_index  = out_bin_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.remaining  = out_rem_q;
	assign rsp.stored_id  = out_id_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one command token in the bin chain");

	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q == S_RUN))
		else $error("token left the chain outside the run state");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == S_RUN) && tok[0].vld)
		else $error("accepted command did not enter the chain");

	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("slot memory written and read for the same command");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok_vld == '0))
		else $error("token in the chain while idle");

endmodule
`default_nettype wire
